>>> rtl/core/cal_pkg.sv
// Shared types and constants of the connection admission limiter.
// Holds the sweep records, the cell write commands, the operation codes, the verdicts and the CSR indices.
// Depends on nothing.
package cal_pkg;

   localparam int IDX_W = 10;
   localparam int CNT_W = 11;

   typedef enum logic [1:0] {
      OP_ATTEMPT = 2'd0,
      OP_RELEASE = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_UNUSED  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      V_ACCEPTED   = 3'd0,
      V_TRACK_FULL = 3'd1,
      V_RATE       = 3'd2,
      V_GLOBAL     = 3'd3,
      V_PEER       = 3'd4,
      V_RELEASED   = 3'd5,
      V_UNKNOWN    = 3'd6,
      V_CLEARED    = 3'd7
   } verdict_type;

   typedef enum logic [2:0] {
      CSR_ATTEMPTS_PER_WINDOW = 3'd0,
      CSR_WINDOW_LENGTH_MS    = 3'd1,
      CSR_MAX_TRACKED_PEERS   = 3'd2,
      CSR_MAX_CONNECTIONS     = 3'd3,
      CSR_MAX_PER_PEER        = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic             act;
      logic             expire_en;
      logic [31:0]      addr;
      logic [31:0]      now;
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      logic [15:0]      attempts;
      logic             free;
      logic [IDX_W-1:0] free_idx;
      logic [CNT_W-1:0] used;
   } rate_rec_type;

   typedef struct packed {
      logic             act;
      logic [31:0]      addr;
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      logic [15:0]      count;
      logic             free;
      logic [IDX_W-1:0] free_idx;
   } peer_rec_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic             alloc;
      logic [31:0]      addr;
      logic [31:0]      expiry;
      logic [15:0]      attempts;
   } rate_cmd_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic             set_valid;
      logic             clr_valid;
      logic [31:0]      addr;
      logic [15:0]      count;
   } peer_cmd_type;

endpackage

>>> rtl/core/cal_rate_cell.sv
// One entry of the attempt-window table, a stage of the rate chain.
// Expires its bucket as the sweep record passes and adds its findings to it.
// Depends on cal_pkg.
module cal_rate_cell import cal_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         clear,
   input  rate_cmd_type cmd,
   input  rate_rec_type rec_in,
   output rate_rec_type rec_out
);

   logic         valid_ff, valid_in;
   logic [31:0]  addr_ff, addr_in;
   logic [31:0]  expiry_ff, expiry_in;
   logic [15:0]  attempts_ff, attempts_in;
   rate_rec_type rec_ff, rec_in_nx;
   logic         expired, live, sel;

   always_comb begin
      expired     = valid_ff && rec_in.expire_en && (expiry_ff <= rec_in.now);
      live        = valid_ff && !expired;
      sel         = cmd.en && (cmd.idx == IDX_W'(IDX));
      valid_in    = valid_ff;
      addr_in     = addr_ff;
      expiry_in   = expiry_ff;
      attempts_in = attempts_ff;
      rec_in_nx   = rec_in;
      if (rec_in.act && expired) begin
         valid_in = 1'b0;
      end
      if (live) begin
         rec_in_nx.used = rec_in.used + CNT_W'(1);
         if (addr_ff == rec_in.addr) begin
            rec_in_nx.hit      = 1'b1;
            rec_in_nx.hit_idx  = IDX_W'(IDX);
            rec_in_nx.attempts = attempts_ff;
         end
      end else if (!rec_in.free) begin
         rec_in_nx.free     = 1'b1;
         rec_in_nx.free_idx = IDX_W'(IDX);
      end
      if (sel) begin
         attempts_in = cmd.attempts;
         if (cmd.alloc) begin
            valid_in  = 1'b1;
            addr_in   = cmd.addr;
            expiry_in = cmd.expiry;
         end
      end
      if (clear) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         rec_ff.act <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         rec_ff.act <= rec_in_nx.act;
      end
      addr_ff               <= addr_in;
      expiry_ff             <= expiry_in;
      attempts_ff           <= attempts_in;
      rec_ff.expire_en      <= rec_in_nx.expire_en;
      rec_ff.addr           <= rec_in_nx.addr;
      rec_ff.now            <= rec_in_nx.now;
      rec_ff.hit            <= rec_in_nx.hit;
      rec_ff.hit_idx        <= rec_in_nx.hit_idx;
      rec_ff.attempts       <= rec_in_nx.attempts;
      rec_ff.free           <= rec_in_nx.free;
      rec_ff.free_idx       <= rec_in_nx.free_idx;
      rec_ff.used           <= rec_in_nx.used;
   end

   assign rec_out = rec_ff;

endmodule

>>> rtl/core/cal_peer_cell.sv
// One entry of the active-connection table, a stage of the peer chain.
// Reports a matching entry or the first free entry to the passing record.
// Depends on cal_pkg.
module cal_peer_cell import cal_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         clear,
   input  peer_cmd_type cmd,
   input  peer_rec_type rec_in,
   output peer_rec_type rec_out
);

   logic         valid_ff, valid_in;
   logic [31:0]  addr_ff, addr_in;
   logic [15:0]  count_ff, count_in;
   peer_rec_type rec_ff, rec_in_nx;
   logic         sel;

   always_comb begin
      sel       = cmd.en && (cmd.idx == IDX_W'(IDX));
      valid_in  = valid_ff;
      addr_in   = addr_ff;
      count_in  = count_ff;
      rec_in_nx = rec_in;
      if (valid_ff) begin
         if (!rec_in.hit && addr_ff == rec_in.addr) begin
            rec_in_nx.hit     = 1'b1;
            rec_in_nx.hit_idx = IDX_W'(IDX);
            rec_in_nx.count   = count_ff;
         end
      end else if (!rec_in.free) begin
         rec_in_nx.free     = 1'b1;
         rec_in_nx.free_idx = IDX_W'(IDX);
      end
      if (sel) begin
         if (cmd.clr_valid) begin
            valid_in = 1'b0;
         end else begin
            count_in = cmd.count;
            if (cmd.set_valid) begin
               valid_in = 1'b1;
               addr_in  = cmd.addr;
            end
         end
      end
      if (clear) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         rec_ff.act <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         rec_ff.act <= rec_in_nx.act;
      end
      addr_ff         <= addr_in;
      count_ff        <= count_in;
      rec_ff.addr     <= rec_in_nx.addr;
      rec_ff.hit      <= rec_in_nx.hit;
      rec_ff.hit_idx  <= rec_in_nx.hit_idx;
      rec_ff.count    <= rec_in_nx.count;
      rec_ff.free     <= rec_in_nx.free;
      rec_ff.free_idx <= rec_in_nx.free_idx;
   end

   assign rec_out = rec_ff;

endmodule

>>> rtl/core/connection_admission_limiter_top.sv
// Top level of the connection admission limiter: controller, two cell chains.
// Depends on cal_pkg, cal_rate_cell and cal_peer_cell.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   opcode, peer_address, now_ms
//   rsp      out        rsp_valid/rsp_ready   admitted, verdict, counts
//   csr      in         csr_wr_en             csr_index, csr_wdata
//
// The sweep record walks both chains one cell per cycle, and the decision step
// waits until it has left the last cell of each. Reset clears every valid bit,
// the total count, the state and the output valid, and sets the CSR defaults.
// A finished result waits in the output register; the next item is taken
// meanwhile, and only the decision step waits for that register to empty.
module connection_admission_limiter_top import cal_pkg::*; #(
   parameter int RATE_ENTRIES = 64,
   parameter int PEER_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_peer_address,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_admitted,
   output logic [2:0]  rsp_verdict,
   output logic [15:0] rsp_active_connections,
   output logic [15:0] rsp_active_for_peer,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DECIDE} state_type;

   // Configuration registers.
   logic [15:0] apw_ff;
   logic [31:0] wlen_ff;
   logic [6:0]  mtp_ff;
   logic [15:0] mc_ff;
   logic [15:0] mpp_ff;

   state_type   state_ff, state_in;
   opcode_type  op_ff;
   logic [31:0] addr_ff;
   logic [31:0] now_ff;
   logic [15:0] total_ff, total_in;
   rate_rec_type rate_res_ff;
   peer_rec_type peer_res_ff;
   logic        rate_done_ff, peer_done_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_adm_ff, adm_in;
   logic [2:0]  rsp_verdict_ff;
   verdict_type verdict_in;
   logic [15:0] rsp_total_ff;
   logic [15:0] rsp_peer_ff, pc_in;

   rate_rec_type rate_bus [RATE_ENTRIES+1];
   peer_rec_type peer_bus [PEER_ENTRIES+1];
   rate_rec_type rate_head;
   peer_rec_type peer_head;
   rate_cmd_type rate_cmd;
   peer_cmd_type peer_cmd;
   logic         clear_all;
   logic         accept, fire;
   logic [32:0]  exp_sum;
   logic [31:0]  exp_sat;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fire      = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_ready);

   // The sweep record enters both chains in the cycle the item is taken.
   always_comb begin
      rate_head           = '0;
      rate_head.act       = accept;
      rate_head.expire_en = (req_opcode == OP_ATTEMPT) && (apw_ff != 16'd0);
      rate_head.addr      = req_peer_address;
      rate_head.now       = req_now_ms;
      peer_head           = '0;
      peer_head.act       = accept;
      peer_head.addr      = req_peer_address;
   end

   assign rate_bus[0] = rate_head;
   assign peer_bus[0] = peer_head;

   for (genvar i = 0; i < RATE_ENTRIES; i++) begin : g_rate
      cal_rate_cell #(.IDX(i)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .clear  (clear_all),
         .cmd    (rate_cmd),
         .rec_in (rate_bus[i]),
         .rec_out(rate_bus[i+1])
      );
   end

   for (genvar j = 0; j < PEER_ENTRIES; j++) begin : g_peer
      cal_peer_cell #(.IDX(j)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .clear  (clear_all),
         .cmd    (peer_cmd),
         .rec_in (peer_bus[j]),
         .rec_out(peer_bus[j+1])
      );
   end

   // The new bucket ends one window after now, saturated at the top of the range.
   assign exp_sum = {1'b0, now_ff} + {1'b0, wlen_ff};
   assign exp_sat = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];

   // Decision step: the attempt checks in order, a release or a clear, and cell writes.
   always_comb begin
      verdict_in = V_ACCEPTED;
      adm_in     = 1'b0;
      pc_in      = 16'd0;
      total_in   = total_ff;
      rate_cmd   = '0;
      peer_cmd   = '0;
      clear_all  = 1'b0;
      case (op_ff)
         OP_ATTEMPT: begin
            if (apw_ff != 16'd0) begin
               if (rate_res_ff.hit) begin
                  if (rate_res_ff.attempts >= apw_ff) begin
                     verdict_in = V_RATE;
                  end else begin
                     rate_cmd.en       = 1'b1;
                     rate_cmd.idx      = rate_res_ff.hit_idx;
                     rate_cmd.attempts = rate_res_ff.attempts + 16'd1;
                  end
               end else if (rate_res_ff.used >= CNT_W'(mtp_ff) || !rate_res_ff.free) begin
                  verdict_in = V_TRACK_FULL;
               end else begin
                  rate_cmd.en       = 1'b1;
                  rate_cmd.idx      = rate_res_ff.free_idx;
                  rate_cmd.alloc    = 1'b1;
                  rate_cmd.addr     = addr_ff;
                  rate_cmd.expiry   = exp_sat;
                  rate_cmd.attempts = 16'd1;
               end
            end
            pc_in = peer_res_ff.hit ? peer_res_ff.count : 16'd0;
            if (verdict_in == V_ACCEPTED) begin
               if ((mc_ff != 16'd0 && total_ff >= mc_ff) || total_ff == 16'hFFFF) begin
                  verdict_in = V_GLOBAL;
               end else if ((mpp_ff != 16'd0 && pc_in >= mpp_ff) || pc_in == 16'hFFFF) begin
                  verdict_in = V_PEER;
               end
            end
            if (verdict_in == V_ACCEPTED && !peer_res_ff.hit && !peer_res_ff.free) begin
               verdict_in = V_TRACK_FULL;
            end
            if (verdict_in == V_ACCEPTED) begin
               peer_cmd.en        = 1'b1;
               peer_cmd.idx       = peer_res_ff.hit ? peer_res_ff.hit_idx
                                                    : peer_res_ff.free_idx;
               peer_cmd.set_valid = !peer_res_ff.hit;
               peer_cmd.addr      = addr_ff;
               peer_cmd.count     = pc_in + 16'd1;
               pc_in              = pc_in + 16'd1;
               total_in           = total_ff + 16'd1;
               adm_in             = 1'b1;
            end
         end
         OP_RELEASE: begin
            if (peer_res_ff.hit) begin
               peer_cmd.en  = 1'b1;
               peer_cmd.idx = peer_res_ff.hit_idx;
               if (peer_res_ff.count <= 16'd1) begin
                  peer_cmd.clr_valid = 1'b1;
               end else begin
                  peer_cmd.count = peer_res_ff.count - 16'd1;
                  pc_in          = peer_res_ff.count - 16'd1;
               end
               if (total_ff != 16'd0) begin
                  total_in = total_ff - 16'd1;
               end
               verdict_in = V_RELEASED;
            end else begin
               verdict_in = V_UNKNOWN;
            end
         end
         OP_CLEAR: begin
            clear_all  = fire;
            total_in   = 16'd0;
            verdict_in = V_CLEARED;
         end
         default: begin
            pc_in      = peer_res_ff.hit ? peer_res_ff.count : 16'd0;
            verdict_in = V_UNKNOWN;
         end
      endcase
      if (!fire) begin
         rate_cmd.en = 1'b0;
         peer_cmd.en = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (rate_done_ff && peer_done_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= 16'd0;
         rate_done_ff <= 1'b0;
         peer_done_ff <= 1'b0;
         apw_ff       <= 16'd0;
         wlen_ff      <= 32'd1000;
         mtp_ff       <= 7'd64;
         mc_ff        <= 16'd0;
         mpp_ff       <= 16'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            total_ff <= total_in;
         end
         if (accept) begin
            rate_done_ff <= 1'b0;
            peer_done_ff <= 1'b0;
         end else begin
            if (rate_bus[RATE_ENTRIES].act) begin
               rate_done_ff <= 1'b1;
            end
            if (peer_bus[PEER_ENTRIES].act) begin
               peer_done_ff <= 1'b1;
            end
         end
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_ATTEMPTS_PER_WINDOW: apw_ff  <= csr_wdata[15:0];
               CSR_WINDOW_LENGTH_MS:    wlen_ff <= csr_wdata;
               CSR_MAX_TRACKED_PEERS:   mtp_ff  <= csr_wdata[6:0];
               CSR_MAX_CONNECTIONS:     mc_ff   <= csr_wdata[15:0];
               CSR_MAX_PER_PEER:        mpp_ff  <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      if (accept) begin
         op_ff   <= opcode_type'(req_opcode);
         addr_ff <= req_peer_address;
         now_ff  <= req_now_ms;
      end
      if (rate_bus[RATE_ENTRIES].act) begin
         rate_res_ff <= rate_bus[RATE_ENTRIES];
      end
      if (peer_bus[PEER_ENTRIES].act) begin
         peer_res_ff <= peer_bus[PEER_ENTRIES];
      end
      if (fire) begin
         rsp_adm_ff     <= adm_in;
         rsp_verdict_ff <= verdict_in;
         rsp_total_ff   <= total_in;
         rsp_peer_ff    <= pc_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_admitted           = rsp_adm_ff;
   assign rsp_verdict            = rsp_verdict_ff;
   assign rsp_active_connections = rsp_total_ff;
   assign rsp_active_for_peer    = rsp_peer_ff;

   // An admitted transfer always carries the accepted verdict.
   a_adm_verdict : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_admitted |-> rsp_verdict == V_ACCEPTED)
      else $error("admitted result without accepted verdict");

   // No sweep record may leave either chain while the block is idle.
   a_idle_quiet : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !rate_bus[RATE_ENTRIES].act && !peer_bus[PEER_ENTRIES].act)
      else $error("sweep record seen while idle");

   // A clear leaves no active connection behind.
   a_clear_zero : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && rsp_verdict == V_CLEARED |-> rsp_active_connections == 16'd0)
      else $error("clear left active connections");

endmodule
